FILE: hw/rtl/riss_pkg.sv
// Shared types for the right interval successor search block.
package riss_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned RIGHT_IDX_W = 6;

  typedef struct packed {
    logic signed [VALUE_W-1:0] interval_start;
    logic signed [VALUE_W-1:0] interval_end;
    logic                      last_interval;
  } item_t;

  typedef struct packed {
    logic                   has_right;
    logic [RIGHT_IDX_W-1:0] right_index;
    logic                   dropped_items;
    logic                   last_result;
  } result_t;

  typedef struct packed {
    logic                      vld;
    logic signed [VALUE_W-1:0] need;
    logic                      found;
    logic signed [VALUE_W-1:0] best_start;
    logic [RIGHT_IDX_W-1:0]    best_idx;
    logic                      last;
  } query_t;

endpackage

FILE: hw/rtl/riss_ram.sv
// Generic single write port RAM with a registered read port.
module riss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/riss_cell.sv
// One search cell: holds a stored start and refines each passing query beat.
module riss_cell #(
  parameter int unsigned Index = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic signed [riss_pkg::VALUE_W-1:0] wr_start_i,
  input  logic                                active_i,
  input  riss_pkg::query_t                    query_i,
  output riss_pkg::query_t                    query_o
);
  import riss_pkg::*;

  logic signed [VALUE_W-1:0] start_q;
  query_t                    query_d;
  query_t                    query_q;
  logic                      hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      start_q <= wr_start_i;
    end
  end

  // Later cells win ties, so an equal start replaces the current best.
  assign hit = active_i && (start_q >= query_i.need) &&
               (!query_i.found || (start_q <= query_i.best_start));

  always_comb begin
    query_d = query_i;
    if (hit) begin
      query_d.found      = 1'b1;
      query_d.best_start = start_q;
      query_d.best_idx   = RIGHT_IDX_W'(Index);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q <= '0;
    end else begin
      query_q <= query_d;
    end
  end

  assign query_o = query_q;

endmodule

FILE: hw/rtl/right_interval_successor_search.sv
// Top level of the right interval successor search block.
// Intervals load one per cycle while busy_o is low; the beat with last_interval
// set closes the batch. Beats past MAX_INTERVALS are dropped and flag every
// result. After the closing beat busy_o stays high until the batch's last result
// has left: each interval's end is read from the end RAM and sent as a query
// down a chain of MAX_INTERVALS cells, each of which registers the query. Results
// then leave in load order, one per cycle on consecutive cycles, each marked by
// strobe_o for a single cycle; the receiver must take each one as it appears.
module right_interval_successor_search #(
  parameter int unsigned MAX_INTERVALS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  riss_pkg::item_t   item_i,
  output logic              strobe_o,
  output riss_pkg::result_t result_o
);
  import riss_pkg::*;

  localparam int unsigned IdxW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CntW = $clog2(MAX_INTERVALS + 1);

  typedef enum logic [2:0] {
    S_LOAD  = 3'b001,
    S_ISSUE = 3'b010,
    S_DRAIN = 3'b100
  } state_e;

  state_e state_d, state_q;
  logic [CntW-1:0] count_d, count_q;
  logic [CntW-1:0] issue_d, issue_q;
  logic overflow_d, overflow_q;
  logic issue_vld_q, issue_last_q;
  logic accept;
  logic store;
  logic issue_now;
  logic issue_end;
  logic signed [VALUE_W-1:0] end_rdata;
  query_t chain [MAX_INTERVALS+1];

  assign accept    = start_i && !busy_o;
  assign store     = accept && (count_q < CntW'(MAX_INTERVALS));
  assign issue_now = (state_q == S_ISSUE);
  assign issue_end = (issue_q == (count_q - CntW'(1)));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    issue_d    = issue_q;
    overflow_d = overflow_q;
    case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (store) begin
            count_d = count_q + CntW'(1);
          end else begin
            overflow_d = 1'b1;
          end
          if (item_i.last_interval) begin
            state_d = S_ISSUE;
            issue_d = '0;
          end
        end
      end
      S_ISSUE: begin
        issue_d = issue_q + CntW'(1);
        if (issue_end) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (chain[MAX_INTERVALS].vld && chain[MAX_INTERVALS].last) begin
          state_d    = S_LOAD;
          count_d    = '0;
          overflow_d = 1'b0;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      count_q      <= '0;
      issue_q      <= '0;
      overflow_q   <= 1'b0;
      issue_vld_q  <= 1'b0;
      issue_last_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      issue_q      <= issue_d;
      overflow_q   <= overflow_d;
      issue_vld_q  <= issue_now;
      issue_last_q <= issue_now && issue_end;
    end
  end

  riss_ram #(
    .Width(VALUE_W),
    .Depth(MAX_INTERVALS)
  ) u_end_ram (
    .clk_i  (clk_i),
    .we_i   (store),
    .waddr_i(count_q[IdxW-1:0]),
    .wdata_i(item_i.interval_end),
    .re_i   (issue_now),
    .raddr_i(issue_q[IdxW-1:0]),
    .rdata_o(end_rdata)
  );

  always_comb begin
    chain[0]            = '0;
    chain[0].vld        = issue_vld_q;
    chain[0].need       = end_rdata;
    chain[0].last       = issue_last_q;
  end

  for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_cell
    riss_cell #(
      .Index(k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (store && (count_q == CntW'(k))),
      .wr_start_i(item_i.interval_start),
      .active_i  (count_q > CntW'(k)),
      .query_i   (chain[k]),
      .query_o   (chain[k+1])
    );
  end

  assign busy_o                 = (state_q != S_LOAD);
  assign strobe_o               = chain[MAX_INTERVALS].vld;
  assign result_o.has_right     = chain[MAX_INTERVALS].found;
  assign result_o.right_index   = chain[MAX_INTERVALS].best_idx;
  assign result_o.dropped_items = overflow_q;
  assign result_o.last_result   = chain[MAX_INTERVALS].last;

  a_no_result_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> !strobe_o)
    else $error("result beat while loading");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_INTERVALS))
    else $error("loaded count above capacity");

  a_issue_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_now |-> (issue_q < count_q))
    else $error("query issued past loaded count");

  a_last_ends_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && result_o.last_result) |=> (!busy_o && (count_q == '0)))
    else $error("batch did not close after final result");

  a_none_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !result_o.has_right) |-> (result_o.right_index == '0))
    else $error("nonzero index without a right interval");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the right interval successor search block.
class successor_tracker #(parameter int unsigned CAPACITY = 64);

  logic signed [riss_pkg::VALUE_W-1:0] starts [CAPACITY];
  logic signed [riss_pkg::VALUE_W-1:0] ends   [CAPACITY];
  int unsigned       held;
  logic              overflowed;
  riss_pkg::result_t due_results [$];
  int unsigned       mismatches;

  function new();
    held       = 0;
    overflowed = 1'b0;
    mismatches = 0;
  endfunction

  function void take_interval(riss_pkg::item_t beat);
    riss_pkg::result_t                   r;
    logic                                found;
    logic signed [riss_pkg::VALUE_W-1:0] best;
    logic [riss_pkg::RIGHT_IDX_W-1:0]    idx;
    if (held < CAPACITY) begin
      starts[held] = beat.interval_start;
      ends[held]   = beat.interval_end;
      held++;
    end else begin
      overflowed = 1'b1;
    end
    if (!beat.last_interval) return;
    for (int unsigned i = 0; i < held; i++) begin
      found = 1'b0;
      best  = '0;
      idx   = '0;
      for (int unsigned j = 0; j < held; j++) begin
        if (starts[j] >= ends[i] && (!found || starts[j] <= best)) begin
          found = 1'b1;
          best  = starts[j];
          idx   = j[riss_pkg::RIGHT_IDX_W-1:0];
        end
      end
      r.has_right     = found;
      r.right_index   = idx;
      r.dropped_items = overflowed;
      r.last_result   = (i + 1 == held);
      due_results.insert(due_results.size(), r);
    end
    held       = 0;
    overflowed = 1'b0;
  endfunction

  function void report(string what, riss_pkg::result_t want, riss_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected has_right=%0d right_index=%0d dropped_items=%0d last_result=%0d",
               what, want.has_right, want.right_index, want.dropped_items, want.last_result);
      $display("  got has_right=%0d right_index=%0d dropped_items=%0d last_result=%0d",
               got.has_right, got.right_index, got.dropped_items, got.last_result);
    end
  endfunction

  function void match_result(riss_pkg::result_t got);
    riss_pkg::result_t want;
    if (due_results.size() == 0) begin
      report("unexpected result", '0, got);
      return;
    end
    want = due_results.pop_front();
    if (got.has_right !== want.has_right || got.right_index !== want.right_index ||
        got.dropped_items !== want.dropped_items || got.last_result !== want.last_result)
      report("result mismatch", want, got);
  endfunction

  function int unsigned pending();
    return due_results.size();
  endfunction

endclass

module tb;

  localparam int unsigned SLOTS       = 64;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 280;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  riss_pkg::item_t   item_i;
  logic              strobe_o;
  riss_pkg::result_t result_o;

  successor_tracker #(SLOTS) tracker;
  int unsigned cycles;
  int unsigned sent;
  int unsigned batch_no;
  int unsigned idle_pct;

  right_interval_successor_search #(
    .MAX_INTERVALS(SLOTS)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .item_i  (item_i),
    .strobe_o(strobe_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    tracker = new();
    cycles  = 0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL right_interval_successor_search");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) tracker.take_interval(item_i);
    if (rst_ni && strobe_o) tracker.match_result(result_o);
  end

  task automatic send_interval(input logic signed [31:0] s, input logic signed [31:0] e,
                               input logic last);
    riss_pkg::item_t beat;
    beat.interval_start = s;
    beat.interval_end   = e;
    beat.last_interval  = last;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= beat;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent++;
  endtask

  function automatic logic signed [31:0] pick_bound();
    logic signed [31:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = $signed($urandom_range(16)) - 8;
      5, 6, 7:       v = $urandom;
      8:             v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default:       v = $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                           : 32'sh80000000 + $urandom_range(3);
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_batch_size(int unsigned n);
    if (n == 4) return SLOTS;
    if (n == 11) return SLOTS + 3;
    if ($urandom_range(9) == 0) return $urandom_range(32, 9);
    return $urandom_range(8, 1);
  endfunction

  initial begin
    int unsigned size;
    rst_ni   = 1'b0;
    start_i  = 1'b0;
    item_i   = '0;
    sent     = 0;
    batch_no = 0;
    idle_pct = 26;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-interval batches at the extremes, with and without a match.
    send_interval(32'sh80000000, 32'sh80000000, 1'b1);
    send_interval(32'sh7fffffff, 32'sh7fffffff, 1'b1);
    send_interval(32'sh80000000, 32'sh7fffffff, 1'b1);
    // Equal starts, where the latest loaded interval wins.
    send_interval(5, 0, 1'b0);
    send_interval(5, 3, 1'b0);
    send_interval(5, 7, 1'b1);
    send_interval(-1, -1, 1'b0);
    send_interval(0, 1, 1'b0);
    send_interval(1, 2, 1'b0);
    send_interval(32'sh80000000, 32'sh7fffffff, 1'b0);
    send_interval(32'sh7fffffff, 32'sh80000000, 1'b1);
    send_interval(3, 10, 1'b0);
    send_interval(10, 20, 1'b0);
    send_interval(20, 3, 1'b0);
    send_interval(10, -5, 1'b1);
    send_interval(32'shaaaaaaaa, 32'sh55555555, 1'b0);
    send_interval(32'sh55555555, 32'shaaaaaaaa, 1'b1);

    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS / 3) idle_pct = 26;
      else if (sent < 2 * RANDOM_ITEMS / 3) idle_pct = 46;
      else idle_pct = 0;
      size = pick_batch_size(batch_no);
      for (int unsigned k = 0; k < size; k++)
        send_interval(pick_bound(), pick_bound(), k + 1 == size);
      batch_no++;
    end

    start_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (2 * SLOTS + 16) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("PASS right_interval_successor_search");
    end else begin
      $display("FAIL right_interval_successor_search");
    end
    $finish;
  end

endmodule
